// ----- sv/rfv_pkg.sv -----
// ----------------------------------------------------------------------------
// rfv_pkg
// Shared types for the record format validator: parse phases and the
// varint status flags passed from the decoder to the parser.
// ----------------------------------------------------------------------------
package rfv_pkg;

    typedef enum logic [13:0] {
        PH_LEN     = 14'h0001,
        PH_ATTR    = 14'h0002,
        PH_TS      = 14'h0004,
        PH_OFF     = 14'h0008,
        PH_KEYLEN  = 14'h0010,
        PH_KEY     = 14'h0020,
        PH_VALLEN  = 14'h0040,
        PH_VAL     = 14'h0080,
        PH_HDRCNT  = 14'h0100,
        PH_HKEYLEN = 14'h0200,
        PH_HKEY    = 14'h0400,
        PH_HVALLEN = 14'h0800,
        PH_HVAL    = 14'h1000,
        PH_DONE    = 14'h2000
    } phase_t;

    // status of the varint including the current byte
    typedef struct packed {
        logic done;       // no continuation bit on this byte
        logic overflow;   // continuation bit on the tenth byte
        logic neg;        // decoded value is negative
        logic zero;       // decoded value is zero
        logic over;       // decoded magnitude above the length limit
        logic ts_match;   // equals latched timestamp delta
        logic off_match;  // equals latched offset delta
    } vi_t;

endpackage

// ----- sv/rfv_varint.sv -----
// ----------------------------------------------------------------------------
// rfv_varint
// Zigzag varlong accumulator: merges one 7-bit group per byte and classifies
// the decoded value against the length limit and the latched deltas.
// ----------------------------------------------------------------------------
module rfv_varint #(
    parameter int LW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          start,
    input  logic          consume,
    input  logic [7:0]    data_byte,
    input  logic [31:0]   lat_ts_zz,
    input  logic [30:0]   lat_off,
    output rfv_pkg::vi_t  vi,
    output logic [LW-1:0] len_value
);

    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;

    logic [63:0] acc_cur;
    logic [3:0]  cnt_cur;
    logic [6:0]  shamt;
    logic [63:0] grp;
    logic [63:0] u;
    logic [62:0] mag;

    assign acc_cur = start ? 64'd0 : acc_reg;
    assign cnt_cur = start ? 4'd0 : cnt_reg;
    assign shamt   = {3'b000, cnt_cur} * 7'd7;
    assign grp     = {57'd0, data_byte[6:0]};
    assign u       = acc_cur | (grp << shamt);
    assign mag     = u[63:1];

    assign vi.done      = !data_byte[7];
    assign vi.overflow  = data_byte[7] && (cnt_cur >= 4'd9);
    assign vi.neg       = u[0];
    assign vi.zero      = (u == 64'd0);
    assign vi.over      = ((mag >> LW) != 63'd0);
    assign vi.ts_match  = (u == {32'd0, lat_ts_zz});
    assign vi.off_match = (u == {32'd0, lat_off, 1'b0});
    assign len_value    = mag[LW-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (step)
        begin
            if (consume)
            begin
                if (data_byte[7])
                begin
                    acc_next = u;
                    if (cnt_cur < 4'd9)
                    begin
                        cnt_next = cnt_cur + 4'd1;
                    end
                    else
                    begin
                        cnt_next = cnt_cur;
                    end
                end
                else
                begin
                    acc_next = 64'd0;
                    cnt_next = 4'd0;
                end
            end
            else if (start)
            begin
                acc_next = 64'd0;
                cnt_next = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 64'd0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sv/rfv_parser.sv -----
// ----------------------------------------------------------------------------
// rfv_parser
// Record layout state machine: walks the fields, counts skipped bytes and
// headers, latches the expected deltas and forms the per-record verdict.
// ----------------------------------------------------------------------------
module rfv_parser #(
    parameter int LW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          last_byte,
    input  logic [30:0]   expected_offset,
    input  logic [31:0]   expected_ts_delta,
    input  rfv_pkg::vi_t  vi,
    input  logic [LW-1:0] len_value,
    output logic          start,
    output logic          consume,
    output logic [30:0]   lat_off,
    output logic [31:0]   lat_ts_zz,
    output logic          record_ok
);

    rfv_pkg::phase_t phase_reg;
    rfv_pkg::phase_t phase_next;
    logic [LW-1:0]   decl_reg;
    logic [LW-1:0]   decl_next;
    logic [LW:0]     bal_reg;
    logic [LW:0]     bal_next;
    logic [LW-1:0]   skip_reg;
    logic [LW-1:0]   skip_next;
    logic [LW-1:0]   hdr_reg;
    logic [LW-1:0]   hdr_next;
    logic [30:0]     off_reg;
    logic [31:0]     ts_zz_reg;
    logic            err_reg;
    logic            err_next;
    logic            start_reg;

    rfv_pkg::phase_t cur_phase;
    rfv_pkg::phase_t hval_exit;
    logic [LW-1:0]   cur_decl;
    logic [LW:0]     cur_bal;
    logic [LW-1:0]   cur_skip;
    logic [LW-1:0]   cur_hdr;
    logic            cur_err;
    logic [LW-1:0]   hdr_dec;
    logic [LW-1:0]   skip_dec;
    logic            len_empty;
    logic            is_vi;
    logic [31:0]     in_ts_zz;

    assign start     = start_reg;
    assign cur_phase = start_reg ? rfv_pkg::PH_LEN : phase_reg;
    assign cur_decl  = start_reg ? '0 : decl_reg;
    assign cur_bal   = start_reg ? '0 : bal_reg;
    assign cur_skip  = start_reg ? '0 : skip_reg;
    assign cur_hdr   = start_reg ? '0 : hdr_reg;
    assign cur_err   = start_reg ? 1'b0 : err_reg;

    assign in_ts_zz  = {expected_ts_delta[30:0], 1'b0} ^ {32{expected_ts_delta[31]}};
    assign lat_off   = start_reg ? expected_offset : off_reg;
    assign lat_ts_zz = start_reg ? in_ts_zz : ts_zz_reg;

    assign hdr_dec   = (cur_hdr != '0) ? cur_hdr - LW'(1) : cur_hdr;
    assign hval_exit = (hdr_dec != '0) ? rfv_pkg::PH_HKEYLEN : rfv_pkg::PH_DONE;
    assign skip_dec  = cur_skip - LW'(1);
    assign len_empty = vi.neg || vi.zero;

    assign bal_next  = ((cur_phase != rfv_pkg::PH_LEN) && !cur_bal[LW]) ?
                       cur_bal + (LW+1)'(1) : cur_bal;

    always_comb
    begin
        case (cur_phase)
            rfv_pkg::PH_ATTR, rfv_pkg::PH_KEY, rfv_pkg::PH_VAL,
            rfv_pkg::PH_HKEY, rfv_pkg::PH_HVAL, rfv_pkg::PH_DONE: is_vi = 1'b0;
            default: is_vi = 1'b1;
        endcase
    end

    assign consume = is_vi && !cur_err;

    always_comb
    begin
        phase_next = cur_phase;
        decl_next  = cur_decl;
        skip_next  = cur_skip;
        hdr_next   = cur_hdr;
        err_next   = cur_err;
        if (!cur_err)
        begin
            case (cur_phase)
                rfv_pkg::PH_ATTR: phase_next = rfv_pkg::PH_TS;
                rfv_pkg::PH_KEY:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) phase_next = rfv_pkg::PH_VALLEN;
                end
                rfv_pkg::PH_VAL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) phase_next = rfv_pkg::PH_HDRCNT;
                end
                rfv_pkg::PH_HKEY:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) phase_next = rfv_pkg::PH_HVALLEN;
                end
                rfv_pkg::PH_HVAL:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        hdr_next   = hdr_dec;
                        phase_next = hval_exit;
                    end
                end
                rfv_pkg::PH_DONE: err_next = 1'b1;
                default:
                begin
                    if (vi.overflow)
                    begin
                        err_next = 1'b1;
                    end
                    else if (vi.done)
                    begin
                        case (cur_phase)
                            rfv_pkg::PH_LEN:
                            begin
                                if (vi.neg || vi.over) err_next = 1'b1;
                                else
                                begin
                                    decl_next  = len_value;
                                    phase_next = rfv_pkg::PH_ATTR;
                                end
                            end
                            rfv_pkg::PH_TS:
                            begin
                                if (!vi.ts_match) err_next = 1'b1;
                                else phase_next = rfv_pkg::PH_OFF;
                            end
                            rfv_pkg::PH_OFF:
                            begin
                                if (!vi.off_match) err_next = 1'b1;
                                else phase_next = rfv_pkg::PH_KEYLEN;
                            end
                            rfv_pkg::PH_KEYLEN:
                            begin
                                if (len_empty) phase_next = rfv_pkg::PH_VALLEN;
                                else if (vi.over) err_next = 1'b1;
                                else
                                begin
                                    skip_next  = len_value;
                                    phase_next = rfv_pkg::PH_KEY;
                                end
                            end
                            rfv_pkg::PH_VALLEN:
                            begin
                                if (len_empty) phase_next = rfv_pkg::PH_HDRCNT;
                                else if (vi.over) err_next = 1'b1;
                                else
                                begin
                                    skip_next  = len_value;
                                    phase_next = rfv_pkg::PH_VAL;
                                end
                            end
                            rfv_pkg::PH_HDRCNT:
                            begin
                                if (len_empty) phase_next = rfv_pkg::PH_DONE;
                                else if (vi.over) err_next = 1'b1;
                                else
                                begin
                                    hdr_next   = len_value;
                                    phase_next = rfv_pkg::PH_HKEYLEN;
                                end
                            end
                            rfv_pkg::PH_HKEYLEN:
                            begin
                                if (len_empty) phase_next = rfv_pkg::PH_HVALLEN;
                                else if (vi.over) err_next = 1'b1;
                                else
                                begin
                                    skip_next  = len_value;
                                    phase_next = rfv_pkg::PH_HKEY;
                                end
                            end
                            default:
                            begin
                                if (len_empty)
                                begin
                                    hdr_next   = hdr_dec;
                                    phase_next = hval_exit;
                                end
                                else if (vi.over) err_next = 1'b1;
                                else
                                begin
                                    skip_next  = len_value;
                                    phase_next = rfv_pkg::PH_HVAL;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign record_ok = !err_next && (phase_next == rfv_pkg::PH_DONE) &&
                       (bal_next == {1'b0, decl_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rfv_pkg::PH_LEN;
            err_reg   <= 1'b0;
            start_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            start_reg <= last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            decl_reg  <= decl_next;
            bal_reg   <= bal_next;
            skip_reg  <= skip_next;
            hdr_reg   <= hdr_next;
            off_reg   <= lat_off;
            ts_zz_reg <= lat_ts_zz;
        end
    end

    // an error sticks until the next record starts
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && !start_reg) |=> err_reg)
        else $error("error flag cleared inside a record");

endmodule

// ----- sv/record_format_validator.sv -----
// ----------------------------------------------------------------------------
// record_format_validator
// Byte-serial checker for v2 log records: one verdict per record.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; a last byte waits in the input register
//   while the previous verdict is stalled.
// Path: a last byte's request passes the input register, then the result
//   register, before out_valid rises.
// Reset: rst_n clears all control state; the first byte after reset
//   starts a new record and latches the expected deltas.
// ----------------------------------------------------------------------------
module record_format_validator #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [30:0] expected_offset,
    input  logic signed [31:0] expected_ts_delta,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        record_valid
);

    logic        in_v_reg;
    logic        in_v_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [30:0] off_reg;
    logic [31:0] ts_reg;
    logic        out_v_reg;
    logic        out_v_next;
    logic        res_reg;

    logic        in_take;
    logic        core_fire;
    logic        start;
    logic        consume;
    logic [30:0] lat_off;
    logic [31:0] lat_ts_zz;
    logic        record_ok;
    logic [LENGTH_WIDTH-1:0] len_value;
    rfv_pkg::vi_t vi;

    assign core_fire = in_v_reg && !(last_reg && out_v_reg && out_stall);
    assign in_stall  = in_v_reg && !core_fire;
    assign in_take   = in_valid && !in_stall;
    assign in_v_next = in_take || (in_v_reg && !core_fire);

    always_comb
    begin
        out_v_next = out_v_reg && out_stall;
        if (core_fire && last_reg)
        begin
            out_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
            off_reg  <= expected_offset;
            ts_reg   <= expected_ts_delta;
        end
        if (core_fire && last_reg)
        begin
            res_reg <= record_ok;
        end
    end

    assign out_valid    = out_v_reg;
    assign record_valid = res_reg;

    rfv_varint #(
        .LW(LENGTH_WIDTH)
    ) u_varint (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (core_fire),
        .start     (start),
        .consume   (consume),
        .data_byte (byte_reg),
        .lat_ts_zz (lat_ts_zz),
        .lat_off   (lat_off),
        .vi        (vi),
        .len_value (len_value)
    );

    rfv_parser #(
        .LW(LENGTH_WIDTH)
    ) u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (core_fire),
        .last_byte         (last_reg),
        .expected_offset   (off_reg),
        .expected_ts_delta (ts_reg),
        .vi                (vi),
        .len_value         (len_value),
        .start             (start),
        .consume           (consume),
        .lat_off           (lat_off),
        .lat_ts_zz         (lat_ts_zz),
        .record_ok         (record_ok)
    );

    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(core_fire && last_reg))
        else $error("verdict raised without a last byte");

    a_last_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        (core_fire && last_reg) |=> out_valid)
        else $error("last byte processed but no verdict");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && !core_fire) |=> (in_v_reg && $stable(last_reg) && $stable(byte_reg)))
        else $error("held input request lost");

endmodule
